@@ sv/text_console_char_writer_core_macros.svh @@
// Assertion macros shared by the text console writer RTL.
`ifndef TEXT_CONSOLE_CHAR_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TCCW_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TCCW_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/tccw_pkg.sv @@
// Types and constants shared by the text console writer modules.
package tccw_pkg;

	// Field widths of the transfer payloads
	localparam int OP_W     = 1;
	localparam int CHAR_W   = 8;
	localparam int RROW_W   = 5;
	localparam int RCOL_W   = 7;
	localparam int OFFSET_W = 11;
	localparam int ATTR_W   = 8;
	localparam int CELL_W   = CHAR_W + ATTR_W;

	// Operation codes
	localparam logic [OP_W-1:0] OP_PUT  = 1'b0;
	localparam logic [OP_W-1:0] OP_READ = 1'b1;

	// Character codes with special handling
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	// Tab stops every eight columns
	localparam int TAB_STEP = 8;

	// Cell values: attribute in the high byte, character in the low byte
	localparam logic [ATTR_W-1:0] DEFAULT_ATTR = 8'h07;
	localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0720;
	localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0700;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [CHAR_W-1:0] char_code;
		logic [RROW_W-1:0] read_row;
		logic [RCOL_W-1:0] read_col;
	} in_item_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] cursor_offset;
		logic [CHAR_W-1:0]   cell_char;
		logic [ATTR_W-1:0]   cell_attr;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCROLL,
		ST_RESP
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;      // input transfer this cycle
		logic cnt_clear;   // restart the sweep counter
		logic clr_step;    // one cell of the reset clearing pass
		logic scroll_step; // one cell of the scroll sweep
		logic out_load;    // load the result register
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic scroll_req;  // offered put item pushes the cursor past the last row
		logic clr_last;    // clearing pass at its last cell
		logic scr_last;    // scroll sweep at its last step
		logic out_free;    // result register can take a new result
	} dp_stat_t;

endpackage

@@ sv/tccw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tccw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/tccw_ctrl.sv @@
// Controller state machine of the text console writer.
module tccw_ctrl import tccw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;

	// State register; reset starts the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (stat.clr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = stat.scroll_req ? ST_SCROLL : ST_RESP;
				end
			end
			ST_SCROLL: begin
				if (stat.scr_last) begin
					state_nxt = ST_RESP;
				end
			end
			ST_RESP: begin
				if (stat.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			ST_IDLE: begin
				in_stall      = 1'b0;
				cmd.accept    = in_valid;
				cmd.cnt_clear = in_valid;
			end
			ST_SCROLL: begin
				cmd.scroll_step = 1'b1;
			end
			ST_RESP: begin
				cmd.out_load = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ sv/tccw_dp.sv @@
// Datapath of the text console writer: cursor, cell RAM, sweep counter, result register.
module tccw_dp import tccw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ATTR_W-1:0] cfg_colour,
	input  in_item_t          in_data,
	input  ctrl_cmd_t         cmd,
	output dp_stat_t          stat,
	input  logic              out_stall,
	output logic              out_valid,
	output out_item_t         out_data
);

	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int MOVE_COUNT = (ROWS - 1) * COLUMNS;
	localparam int CW         = $clog2(COLUMNS);
	localparam int CXW        = CW + 1;
	localparam int RW         = $clog2(ROWS);
	localparam int RXW        = RW + 1;
	localparam int AW         = $clog2(CELL_COUNT);
	localparam int NW         = $clog2(CELL_COUNT + 1);

	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic [ATTR_W-1:0] colour_q;
	logic [NW-1:0]     cnt_q;
	logic              read_q;
	logic              in_range_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic [CXW-1:0]    ncol;
	logic [RXW-1:0]    nrow;
	logic              wrap_row;
	logic              is_put;
	logic              printable;
	logic              rd_in_range;
	logic [AW-1:0]     cur_addr;
	logic [AW-1:0]     rd_addr;
	logic [NW-1:0]     cnt_dec;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	assign is_put    = (in_data.operation == OP_PUT);
	assign printable = (in_data.char_code >= CH_SPACE);
	assign cur_addr  = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);

	// Read address and range check of a read item
	assign rd_in_range = (32'(in_data.read_row) < ROWS) && (32'(in_data.read_col) < COLUMNS);
	assign rd_addr     = AW'(in_data.read_row) * AW'(COLUMNS) + AW'(in_data.read_col);

	// Cursor after a put item
	always_comb begin
		ncol = {1'b0, col_q};
		nrow = {1'b0, row_q};
		case (in_data.char_code)
			CH_BS: begin
				if (col_q != '0) begin
					ncol = ncol - CXW'(1);
				end else if (row_q != '0) begin
					ncol = CXW'(COLUMNS - 1);
					nrow = nrow - RXW'(1);
				end
			end
			CH_TAB: begin
				ncol = (ncol + CXW'(TAB_STEP)) & ~CXW'(TAB_STEP - 1);
			end
			CH_CR: begin
				ncol = '0;
			end
			CH_LF: begin
				ncol = '0;
				nrow = nrow + RXW'(1);
			end
			default: begin
				if (printable) begin
					ncol = ncol + CXW'(1);
				end
			end
		endcase
		// column wrap
		if (ncol >= CXW'(COLUMNS)) begin
			ncol = '0;
			nrow = nrow + RXW'(1);
		end
		// past the last row: scroll and stay on the last row
		wrap_row = (nrow >= RXW'(ROWS));
		if (wrap_row) begin
			nrow = RXW'(ROWS - 1);
		end
	end

	// Cursor and colour registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			colour_q <= DEFAULT_ATTR;
		end else begin
			if (cmd.accept && is_put) begin
				col_q <= ncol[CW-1:0];
				row_q <= nrow[RW-1:0];
			end
			if (cfg_we) begin
				colour_q <= cfg_colour;
			end
		end
	end

	// Sweep counter for the clearing pass and the scroll
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clear) begin
			cnt_q <= '0;
		end else if (cmd.clr_step || cmd.scroll_step) begin
			cnt_q <= cnt_q + NW'(1);
		end
	end

	assign cnt_dec = cnt_q - NW'(1);

	// Kind of the item in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_q     <= 1'b0;
			in_range_q <= 1'b0;
		end else if (cmd.accept) begin
			read_q     <= (in_data.operation == OP_READ);
			in_range_q <= rd_in_range;
		end
	end

	// RAM port steering: clear, printable write, cell read, scroll copy and blank
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_addr;
		ram_wdata = {colour_q, in_data.char_code};
		ram_re    = 1'b0;
		ram_raddr = rd_addr;
		if (cmd.clr_step) begin
			ram_we    = 1'b1;
			ram_waddr = cnt_q[AW-1:0];
			ram_wdata = RESET_CELL;
		end else if (cmd.scroll_step) begin
			// read one row ahead, write the cell read last cycle
			ram_re    = (cnt_q < NW'(MOVE_COUNT));
			ram_raddr = AW'(cnt_q + NW'(COLUMNS));
			ram_we    = (cnt_q != '0);
			ram_waddr = cnt_dec[AW-1:0];
			ram_wdata = (cnt_q <= NW'(MOVE_COUNT)) ? ram_rdata : BLANK_CELL;
		end else if (cmd.accept) begin
			ram_we = is_put && printable;
			ram_re = !is_put && rd_in_range;
		end
	end

	tccw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELL_COUNT)
	) u_cell_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.cursor_offset <= OFFSET_W'(cur_addr);
			if (read_q && in_range_q) begin
				out_q.cell_char <= ram_rdata[CHAR_W-1:0];
				out_q.cell_attr <= ram_rdata[CELL_W-1:CHAR_W];
			end else begin
				out_q.cell_char <= '0;
				out_q.cell_attr <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Status
	assign stat.scroll_req = is_put && wrap_row;
	assign stat.clr_last   = (cnt_q == NW'(CELL_COUNT - 1));
	assign stat.scr_last   = (cnt_q == NW'(CELL_COUNT));
	assign stat.out_free   = !out_valid_q || !out_stall;

endmodule

@@ sv/text_console_char_writer_core.sv @@
// Top level of the text console writer: controller, datapath and checks.
`include "text_console_char_writer_core_macros.svh"

// Text console writer. Keeps a ROWS x COLUMNS store of 16-bit cells (attribute
// high byte, character low byte) and a cursor. A put transfer interprets one
// character byte (backspace, tab, carriage return, line feed, printable);
// a read transfer returns one cell. Each input transfer yields one result
// transfer carrying the cursor offset after the item. After reset the block
// sweeps the cell RAM to space/0x07, one cell per cycle, over all ROWS*COLUMNS
// cells (2000 at the default size) before it takes input; configuration
// writes are taken throughout. Input is taken only in the idle state: after
// a read or a put that does not scroll, the block waits in the response
// state until the result register is free. A put that runs past the last row
// scrolls: the cell RAM, with one write port, is swept one cell per cycle.
module text_console_char_writer_core import tccw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [ATTR_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output out_item_t         out_data
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// Colour register is always writable
	assign cfg_ready = 1'b1;

	tccw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	tccw_dp #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_colour (cfg_data),
		.in_data    (in_data),
		.cmd        (cmd),
		.stat       (stat),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_data   (out_data)
	);

	// One item at a time: no transfer right after a transfer
	`TCCW_ASSERT_NXT(a_one_item, in_valid && !in_stall, in_stall, "input taken back to back")
	// A new result never overwrites one still waiting
	`TCCW_ASSERT_IMP(a_no_overwrite, cmd.out_load, stat.out_free, "result register overwritten")
	// Sweeps never run alongside an accepted item
	`TCCW_ASSERT_IMP(a_sweep_excl, cmd.accept, !cmd.scroll_step && !cmd.clr_step,
		"sweep overlaps an accepted item")

endmodule
